>>> hdl/keyword_ident_string_tokenizer_defines.svh
// Assertion macros used by the tokenizer top level.
`ifndef KEYWORD_IDENT_STRING_TOKENIZER_DEFINES_SVH
`define KEYWORD_IDENT_STRING_TOKENIZER_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define KITST_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tokenizer invariant violated");

// Checks that a consequent holds in the cycle after an antecedent.
`define KITST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer sequence violated");

`endif

>>> hdl/kitst_pkg.sv
// Types, constants and helper functions of the tokenizer.
package kitst_pkg;

    localparam int MAX_TEXT   = 32;
    localparam int LEN_W      = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_EOF    = 8'h00;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_I  = 8'h69;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_H  = 8'h68;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    typedef enum logic [2:0] {
        KIND_EOF     = 3'd0,
        KIND_IF      = 3'd1,
        KIND_THEN    = 3'd2,
        KIND_IDENT   = 3'd3,
        KIND_STRING  = 3'd4,
        KIND_LPAREN  = 3'd5,
        KIND_RPAREN  = 3'd6,
        KIND_UNKNOWN = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_STRING = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KW_NONE = 3'd0,
        KW_I    = 3'd1,
        KW_IF   = 3'd2,
        KW_T    = 3'd3,
        KW_TH   = 3'd4,
        KW_THE  = 3'd5,
        KW_THEN = 3'd6,
        KW_DEAD = 3'd7
    } kw_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] text_char;
        logic       has_char;
        logic       last;
        kind_t      token_kind;
        logic       truncated;
    } res_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [2:0] count;
        logic       room2;
    } qstat_t;

    localparam res_t RES_NONE = '{8'h00, 1'b0, 1'b0, KIND_EOF, 1'b0};

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_letter(c) || (c inside {[8'h30:8'h39]}) || c == CH_DOT || c == CH_UNDER;
    endfunction

    // Next keyword-match state after one more identifier character.
    function automatic kw_t advance_kw(input kw_t p, input logic [7:0] c);
        kw_t n;
        n = KW_DEAD;
        case (p)
            KW_NONE: n = (c == CH_LOW_I) ? KW_I : (c == CH_LOW_T) ? KW_T : KW_DEAD;
            KW_I:    n = (c == CH_LOW_F) ? KW_IF : KW_DEAD;
            KW_T:    n = (c == CH_LOW_H) ? KW_TH : KW_DEAD;
            KW_TH:   n = (c == CH_LOW_E) ? KW_THE : KW_DEAD;
            KW_THE:  n = (c == CH_LOW_N) ? KW_THEN : KW_DEAD;
            default: n = KW_DEAD;
        endcase
        return n;
    endfunction

    function automatic res_t char_res(input logic [7:0] c);
        return '{c, 1'b1, 1'b0, KIND_EOF, 1'b0};
    endfunction

    function automatic res_t close_res(input kind_t k, input logic trunc);
        return '{8'h00, 1'b0, 1'b1, k, trunc};
    endfunction

endpackage

>>> hdl/kitst_in_if.sv
// Handshake channel that carries source bytes.
interface kitst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

>>> hdl/kitst_out_if.sv
// Handshake channel that carries token results.
interface kitst_out_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           text_char;
    logic                 has_char;
    logic                 last;
    logic [2:0]           token_kind;
    logic                 truncated;

    modport source (output valid, output text_char, output has_char, output last,
                    output token_kind, output truncated, input ready);
    modport sink   (input valid, input text_char, input has_char, input last,
                    input token_kind, input truncated, output ready);
endinterface

>>> hdl/kitst_step.sv
// Scanner state and the per-byte step logic that yields up to two results.
module kitst_step #(
    parameter int MaxText = kitst_pkg::MAX_TEXT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          ch,
    output kitst_pkg::res_t     res0,
    output kitst_pkg::res_t     res1,
    output logic [1:0]          res_cnt
);

    localparam logic [kitst_pkg::LEN_W-1:0] LIMIT = kitst_pkg::LEN_W'(MaxText);

    kitst_pkg::mode_t               mode_reg, mode_next;
    kitst_pkg::kw_t                 kw_reg, kw_next;
    logic [kitst_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                           ovf_reg, ovf_next;

    // Outcome of starting a fresh token with this byte.
    kitst_pkg::res_t    st_res;
    logic               st_has;
    kitst_pkg::mode_t   st_mode;
    kitst_pkg::kw_t     st_kw;
    logic [kitst_pkg::LEN_W-1:0] st_len;

    always_comb
    begin
        st_res  = kitst_pkg::RES_NONE;
        st_has  = 1'b0;
        st_mode = kitst_pkg::MODE_IDLE;
        st_kw   = kitst_pkg::KW_NONE;
        st_len  = '0;
        if (ch == kitst_pkg::CH_EOF)
        begin
            st_res = kitst_pkg::close_res(kitst_pkg::KIND_EOF, 1'b0);
            st_has = 1'b1;
        end
        else if (kitst_pkg::is_space(ch))
        begin
            st_has = 1'b0;
        end
        else if (kitst_pkg::is_letter(ch))
        begin
            // The first letter is always emitted and counted, whatever the limit.
            st_mode = kitst_pkg::MODE_IDENT;
            st_kw   = kitst_pkg::advance_kw(kitst_pkg::KW_NONE, ch);
            st_len  = kitst_pkg::LEN_W'(1);
            st_res  = kitst_pkg::char_res(ch);
            st_has  = 1'b1;
        end
        else if (ch == kitst_pkg::CH_QUOTE)
        begin
            st_mode = kitst_pkg::MODE_STRING;
        end
        else
        begin
            st_res = kitst_pkg::char_res(ch);
            st_res.last = 1'b1;
            st_res.token_kind = (ch == kitst_pkg::CH_LPAREN) ? kitst_pkg::KIND_LPAREN :
                                (ch == kitst_pkg::CH_RPAREN) ? kitst_pkg::KIND_RPAREN :
                                                               kitst_pkg::KIND_UNKNOWN;
            st_has = 1'b1;
        end
    end

    // Main step: continue the open token or start a new one.
    always_comb
    begin
        mode_next = mode_reg;
        kw_next   = kw_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        res0      = kitst_pkg::RES_NONE;
        res1      = kitst_pkg::RES_NONE;
        res_cnt   = 2'd0;
        case (mode_reg)
            kitst_pkg::MODE_IDENT:
            begin
                if (kitst_pkg::is_ident(ch))
                begin
                    kw_next = kitst_pkg::advance_kw(kw_reg, ch);
                    if (len_reg < LIMIT)
                    begin
                        res0     = kitst_pkg::char_res(ch);
                        res_cnt  = 2'd1;
                        len_next = len_reg + kitst_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    // The ending byte closes the identifier, then acts as in idle.
                    res0 = kitst_pkg::close_res(
                        (kw_reg == kitst_pkg::KW_IF)   ? kitst_pkg::KIND_IF   :
                        (kw_reg == kitst_pkg::KW_THEN) ? kitst_pkg::KIND_THEN :
                                                         kitst_pkg::KIND_IDENT, ovf_reg);
                    res1      = st_res;
                    res_cnt   = st_has ? 2'd2 : 2'd1;
                    mode_next = st_mode;
                    kw_next   = st_kw;
                    len_next  = st_len;
                    ovf_next  = 1'b0;
                end
            end
            kitst_pkg::MODE_STRING:
            begin
                if (ch == kitst_pkg::CH_QUOTE || ch == kitst_pkg::CH_EOF)
                begin
                    // End of input inside a string also emits the eof token.
                    res0      = kitst_pkg::close_res(kitst_pkg::KIND_STRING, ovf_reg);
                    res1      = kitst_pkg::close_res(kitst_pkg::KIND_EOF, 1'b0);
                    res_cnt   = (ch == kitst_pkg::CH_EOF) ? 2'd2 : 2'd1;
                    mode_next = kitst_pkg::MODE_IDLE;
                    kw_next   = kitst_pkg::KW_NONE;
                    len_next  = '0;
                    ovf_next  = 1'b0;
                end
                else if (len_reg < LIMIT)
                begin
                    res0     = kitst_pkg::char_res(ch);
                    res_cnt  = 2'd1;
                    len_next = len_reg + kitst_pkg::LEN_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            default:
            begin
                res0      = st_res;
                res_cnt   = st_has ? 2'd1 : 2'd0;
                mode_next = st_mode;
                kw_next   = st_kw;
                len_next  = st_len;
                ovf_next  = 1'b0;
            end
        endcase
    end

    // Scanner state advances once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= kitst_pkg::MODE_IDLE;
            kw_reg   <= kitst_pkg::KW_NONE;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            kw_reg   <= kw_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

>>> hdl/kitst_queue.sv
// Result queue that takes up to two results per cycle and hands out one while tok_out is ready.
module kitst_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  kitst_pkg::res_t     res0,
    input  kitst_pkg::res_t     res1,
    output kitst_pkg::qstat_t   stat,
    kitst_out_if.source         tok_out
);

    localparam int PTR_W = $clog2(kitst_pkg::QUEUE_DEPTH);

    kitst_pkg::res_t    q_reg [kitst_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [2:0]         count_reg, count_next;
    logic               pop;
    kitst_pkg::res_t    head_res;

    assign pop = tok_out.valid && tok_out.ready;

    // Pointer and occupancy bookkeeping.
    always_comb
    begin
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push_cnt);
        count_next = count_reg + 3'(push_cnt) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry writes; the second result goes one slot after the first.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            q_reg[tail_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            q_reg[tail_reg + PTR_W'(1)] <= res1;
        end
    end

    assign head_res           = q_reg[head_reg];
    assign tok_out.valid      = (count_reg != 3'd0);
    assign tok_out.text_char  = head_res.text_char;
    assign tok_out.has_char   = head_res.has_char;
    assign tok_out.last       = head_res.last;
    assign tok_out.token_kind = head_res.token_kind;
    assign tok_out.truncated  = head_res.truncated;

    assign stat.count = count_reg;
    assign stat.room2 = (count_reg <= 3'(kitst_pkg::QUEUE_DEPTH - 2));

endmodule

>>> hdl/keyword_ident_string_tokenizer.sv
// Top level of the keyword, identifier and string tokenizer.
// Usage:
//   tok_in carries one source byte per transfer; byte 0 marks end of input and
//   makes the block emit an eof token, after which it is idle between tokens.
//   tok_out carries one result per transfer: a text character (has_char), a
//   token close (last) with its kind and truncated flag, or both at once.
// Path: a transferred byte is held in the input register until the queue has
//   room for two results; its results are then written into the queue and offered.
// Throughput: one byte per cycle while each byte yields at most one result and
//   tok_out is ready; a byte that yields two results takes two output transfers,
//   so the sustained rate is set by the one-result-per-cycle output queue.
// Structure: input register, combinational step logic, four-entry result queue.
// The input register holds its byte while the queue has fewer than two free
// entries, so a stalled receiver backs up into tok_in.ready without loss.
// Reset clears the scanner to idle and empties the queue; no clearing pass.
`include "keyword_ident_string_tokenizer_defines.svh"
module keyword_ident_string_tokenizer #(
    parameter int MaxText = kitst_pkg::MAX_TEXT
) (
    input  logic        clk,
    input  logic        rst_n,
    kitst_in_if.sink    tok_in,
    kitst_out_if.source tok_out
);

    logic               in_vld_reg, in_vld_next;
    logic [7:0]         ch_reg;
    logic               fire;
    kitst_pkg::res_t    res0, res1;
    logic [1:0]         res_cnt;
    kitst_pkg::qstat_t  qstat;

    // A held byte is processed once the queue can absorb two results.
    assign fire         = in_vld_reg && qstat.room2;
    assign tok_in.ready = !in_vld_reg || qstat.room2;
    assign in_vld_next  = tok_in.ready ? tok_in.valid : in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.valid && tok_in.ready)
        begin
            ch_reg <= tok_in.ch;
        end
    end

    kitst_step #(
        .MaxText(MaxText)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .ch      (ch_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    kitst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (fire ? res_cnt : 2'd0),
        .res0     (res0),
        .res1     (res1),
        .stat     (qstat),
        .tok_out  (tok_out)
    );

    // The queue never overfills.
    `KITST_ASSERT_ALWAYS(a_queue_bound, qstat.count <= 3'(kitst_pkg::QUEUE_DEPTH))
    // A byte stuck in the input register stays put until processed.
    `KITST_ASSERT_NEXT(a_hold_byte, in_vld_reg && !qstat.room2, in_vld_reg && $stable(ch_reg))
    // A result without a character always closes a token.
    `KITST_ASSERT_ALWAYS(a_empty_is_close, !tok_out.valid || tok_out.has_char || tok_out.last)

endmodule
